>>> design/psfs_pkg.sv
// Shared types, widths and constants of the pressure sensor frame scaler.
package psfs_pkg;

  localparam int STATUS_W = 2;
  localparam int PRESS_W  = 18;
  localparam int TEMP_W   = 15;
  localparam int DIFF_W   = 15;
  localparam int MODE_W   = 2;
  localparam int OFS_W    = 14;
  localparam int FS_W     = 16;

  localparam int RING_DEPTH_DEF = 8;

  // Queue depths. The result queue must hold every item in the back pipeline.
  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 8;
  localparam int OUT_LVL_W = $clog2(OUT_DEPTH + 1);

  // Frame modes.
  localparam logic [MODE_W-1:0] MODE_PRESS_ONLY = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PARTIAL    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FULL       = 2'd2;

  // Register indexes.
  localparam logic [1:0] REG_FRAME_MODE = 2'd0;
  localparam logic [1:0] REG_OFFSET     = 2'd1;
  localparam logic [1:0] REG_FULL_SCALE = 2'd2;

  localparam logic [MODE_W-1:0] FRAME_MODE_RST = MODE_FULL;
  localparam logic [OFS_W-1:0]  OFFSET_RST     = 14'd1638;
  localparam logic [FS_W-1:0]   FULL_SCALE_RST = 16'd10000;

  typedef struct packed {
    logic [MODE_W-1:0] frame_mode;
    logic [OFS_W-1:0]  offset_counts;
    logic [FS_W-1:0]   full_scale;
  } cfg_t;

  // Decoded frame handed from the front to the back.
  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic signed [DIFF_W-1:0] diff;
    logic signed [TEMP_W-1:0] temp;
  } mid_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [PRESS_W-1:0] press_now;
    logic signed [TEMP_W-1:0]  temp_now;
    logic signed [PRESS_W-1:0] press_avg;
    logic signed [TEMP_W-1:0]  temp_avg;
  } res_t;

endpackage

>>> design/pressure_sensor_frame_scaler_unit.sv
// Top level of the pressure sensor frame scaler with its configuration registers.
//
// Each frame pushed in gives exactly one result: the status bits, the scaled
// pressure in milli-units, the temperature in hundredths of a degree, and the
// floor means of the last RING_DEPTH values of each (the rings start at zero).
// A new frame is taken every cycle while full is low. A frame waits in the
// queue between the decoder and the pipeline, then passes the multiplier, the
// scaling step, the ring update and the two averaging divider steps, each
// registered, before it enters the result queue and can be popped.
// Full rises only when the result queue backs up into the two-entry queue
// between the decoder and the pipeline. Registers sit at byte addresses 0
// (frame mode), 4 (zero-pressure offset) and 8 (full scale); the user must write
// them only while no frame is in flight, as the block itself does not enforce it.
module pressure_sensor_frame_scaler_unit
  import psfs_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic [7:0]                 in_byte0,
  input  logic [7:0]                 in_byte1,
  input  logic [7:0]                 in_byte2,
  input  logic [7:0]                 in_byte3,
  output logic                       empty,
  input  logic                       pop,
  output logic [STATUS_W-1:0]        out_status_code,
  output logic signed [PRESS_W-1:0]  out_pressure_now,
  output logic signed [TEMP_W-1:0]   out_temperature_now,
  output logic signed [PRESS_W-1:0]  out_pressure_average,
  output logic signed [TEMP_W-1:0]   out_temperature_average,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [3:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  cfg_t       cfg_r;
  logic       cfg_wr;
  logic [1:0] cfg_idx;

  logic      mid_wr, mid_rd, mid_empty, mid_full;
  mid_item_t mid_wdata, mid_rdata;

  logic                 res_wr;
  res_t                 res_wdata, res_rdata;
  logic [OUT_LVL_W-1:0] out_level;

  // Configuration registers.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_mode    <= FRAME_MODE_RST;
      cfg_r.offset_counts <= OFFSET_RST;
      cfg_r.full_scale    <= FULL_SCALE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FRAME_MODE: cfg_r.frame_mode    <= pwdata[MODE_W-1:0];
        REG_OFFSET:     cfg_r.offset_counts <= pwdata[OFS_W-1:0];
        REG_FULL_SCALE: cfg_r.full_scale    <= pwdata[FS_W-1:0];
        default:        cfg_r               <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FRAME_MODE: prdata = 32'(cfg_r.frame_mode);
      REG_OFFSET:     prdata = 32'(cfg_r.offset_counts);
      REG_FULL_SCALE: prdata = 32'(cfg_r.full_scale);
      default:        prdata = '0;
    endcase
  end

  psfs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .push    (push),
    .full    (full),
    .in_byte0(in_byte0),
    .in_byte1(in_byte1),
    .in_byte2(in_byte2),
    .in_byte3(in_byte3),
    .mid_full(mid_full),
    .mid_wr  (mid_wr),
    .mid_item(mid_wdata)
  );

  psfs_fifo #(
    .WIDTH($bits(mid_item_t)),
    .DEPTH(MID_DEPTH)
  ) u_mid_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (mid_wr),
    .wr_data(mid_wdata),
    .rd_en  (mid_rd),
    .rd_data(mid_rdata),
    .empty  (mid_empty),
    .full   (mid_full),
    .level  ()
  );

  psfs_back #(
    .RING_DEPTH(RING_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .full_scale(cfg_r.full_scale),
    .mid_empty (mid_empty),
    .mid_item  (mid_rdata),
    .mid_rd    (mid_rd),
    .out_level (out_level),
    .res_wr    (res_wr),
    .res       (res_wdata)
  );

  psfs_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (res_wr),
    .wr_data(res_wdata),
    .rd_en  (pop),
    .rd_data(res_rdata),
    .empty  (empty),
    .full   (),
    .level  (out_level)
  );

  assign out_status_code         = res_rdata.status;
  assign out_pressure_now        = res_rdata.press_now;
  assign out_temperature_now     = res_rdata.temp_now;
  assign out_pressure_average    = res_rdata.press_avg;
  assign out_temperature_average = res_rdata.temp_avg;

endmodule

>>> design/psfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module psfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/psfs_fifo.sv
// Small show-ahead register queue used between the front and the back and for results.
module psfs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       rd_en,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [LW-1:0]    level_r;
  logic             do_wr, do_rd;

  assign empty = (level_r == '0);
  assign full  = (level_r == LW'(DEPTH));
  assign level = level_r;
  assign rd_data = mem_r[rd_ptr_r];

  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   level_r <= level_r + 1'b1;
        2'b01:   level_r <= level_r - 1'b1;
        default: level_r <= level_r;
      endcase
    end
  end

endmodule

>>> design/psfs_front.sv
// Front end: accepts sensor frames, tracks the held temperature bytes and decodes counts.
module psfs_front
  import psfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte0,
  input  logic [7:0] in_byte1,
  input  logic [7:0] in_byte2,
  input  logic [7:0] in_byte3,
  input  logic       mid_full,
  output logic       mid_wr,
  output mid_item_t  mid_item
);

  localparam logic [22:0] TEMP_GAIN   = 23'd2501;
  localparam logic [22:0] TEMP_ROUND  = 23'd128;
  localparam logic [15:0] TEMP_OFFSET = 16'd5000;

  logic        accept;
  logic [7:0]  held2_r, held3_r;
  logic [7:0]  hb2, hb3;
  logic [10:0] tcount;
  logic [22:0] tprod;
  logic [15:0] temp_wide;
  logic [13:0] pcount;
  logic        is_press_only, is_partial;

  assign full   = mid_full;
  assign accept = push && !mid_full;
  assign mid_wr = accept;

  assign is_press_only = (cfg.frame_mode == MODE_PRESS_ONLY);
  assign is_partial    = (cfg.frame_mode == MODE_PARTIAL);

  // Pressure-only frames reuse the stored bytes; partial frames refresh only byte2.
  assign hb2 = is_press_only ? held2_r : in_byte2;
  assign hb3 = (is_press_only || is_partial) ? held3_r : in_byte3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held2_r <= '0;
      held3_r <= '0;
    end else if (accept) begin
      held2_r <= hb2;
      held3_r <= hb3;
    end
  end

  assign tcount    = is_partial ? {3'b000, hb2} : {hb2, hb3[7:5]};
  assign tprod     = 23'(tcount) * TEMP_GAIN + TEMP_ROUND;
  assign temp_wide = {1'b0, tprod[22:8]} - TEMP_OFFSET;
  assign pcount    = {in_byte0[5:0], in_byte1};

  always_comb begin
    mid_item.status = in_byte0[7:6];
    mid_item.diff   = DIFF_W'({1'b0, pcount} - {1'b0, cfg.offset_counts});
    mid_item.temp   = temp_wide[TEMP_W-1:0];
  end

endmodule

>>> design/psfs_avg_div.sv
// Two-stage floor division of a biased ring sum by the ring depth.
module psfs_avg_div #(
  parameter  int VW    = 18,
  parameter  int DEPTH = 8,
  localparam int UW    = VW + $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic [UW-1:0] sum_biased,
  output logic [VW-1:0] avg
);

  // The sum carries a bias of DEPTH * 2^(VW-1), so the quotient is offset by 2^(VW-1).
  localparam logic [UW-1:0] RECIP   = UW'((64'd1 << UW) / 64'(DEPTH));
  localparam logic [UW-1:0] DEPTH_U = UW'(DEPTH);
  localparam logic [VW-1:0] HALF    = {1'b1, {(VW-1){1'b0}}};

  logic [2*UW-1:0] prod_r;
  logic [UW-1:0]   u_r;
  logic [VW-1:0]   q_est;
  logic [UW-1:0]   rem;
  logic            inc;
  logic [VW-1:0]   avg_r;

  // The reciprocal estimate is at most one below the true quotient.
  assign q_est = prod_r[UW+VW-1:UW];
  assign rem   = u_r - UW'(UW'(q_est) * DEPTH_U);
  assign inc   = (rem >= DEPTH_U);

  always_ff @(posedge clk) begin
    prod_r <= (2*UW)'(sum_biased) * (2*UW)'(RECIP);
    u_r    <= sum_biased;
    avg_r  <= q_est + VW'(inc) - HALF;
  end

  assign avg = avg_r;

endmodule

>>> design/psfs_back.sv
// Back end: scales pressure, updates the averaging rings and forms result items.
module psfs_back
  import psfs_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [FS_W-1:0]      full_scale,
  input  logic                 mid_empty,
  input  mid_item_t            mid_item,
  output logic                 mid_rd,
  input  logic [OUT_LVL_W-1:0] out_level,
  output logic                 res_wr,
  output res_t                 res
);

  localparam int AW    = $clog2(RING_DEPTH);
  localparam int PUW   = PRESS_W + $clog2(RING_DEPTH);
  localparam int TUW   = TEMP_W + $clog2(RING_DEPTH);
  localparam int OCC_W = OUT_LVL_W + 1;
  localparam int RW    = PRESS_W + TEMP_W;

  localparam logic [PUW-1:0] PBIAS = PUW'(RING_DEPTH) << (PRESS_W - 1);
  localparam logic [TUW-1:0] TBIAS = TUW'(RING_DEPTH) << (TEMP_W - 1);

  // Stage valids: multiply, scale, ring update, divide step one, divide step two.
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [2:0]       inflight;
  logic [OCC_W-1:0] occ;
  logic             issue;

  logic [STATUS_W-1:0]       s1_status_r, s2_status_r, s3_status_r, s4_status_r, s5_status_r;
  logic signed [TEMP_W-1:0]  s1_temp_r, s2_temp_r, s3_temp_r, s4_temp_r, s5_temp_r;
  logic signed [31:0]        s1_mul_r;
  logic signed [33:0]        mul5;
  logic signed [PRESS_W-1:0] s2_press_r, s3_press_r, s4_press_r, s5_press_r;

  logic [AW-1:0]         slot_r, slot_nxt, s2_slot_r;
  logic [RING_DEPTH-1:0] ring_vld_r;
  logic [RW-1:0]         ring_rdata;
  logic signed [PRESS_W-1:0] old_press;
  logic signed [TEMP_W-1:0]  old_temp;
  logic [PUW-1:0]        psum_r, psum_nxt;
  logic [TUW-1:0]        tsum_r, tsum_nxt;
  logic [PRESS_W-1:0]    press_avg;
  logic [TEMP_W-1:0]     temp_avg;

  // Reserve a result queue entry for every item in flight before issuing another.
  assign inflight = 3'($countones({v1_r, v2_r, v3_r, v4_r, v5_r}));
  assign occ      = {1'b0, out_level} + OCC_W'(inflight);
  assign issue    = !mid_empty && (occ < OCC_W'(OUT_DEPTH));
  assign mid_rd   = issue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // Pressure scaling: (diff * full_scale * 5) shifted down by 16 with floor rounding.
  assign mul5 = (34'(s1_mul_r) <<< 2) + 34'(s1_mul_r);

  always_ff @(posedge clk) begin
    s1_mul_r    <= 32'($signed(mid_item.diff) * $signed({1'b0, full_scale}));
    s1_status_r <= mid_item.status;
    s1_temp_r   <= mid_item.temp;
    s2_press_r  <= mul5[33:16];
    s2_status_r <= s1_status_r;
    s2_temp_r   <= s1_temp_r;
    s2_slot_r   <= slot_r;
    s3_press_r  <= s2_press_r;
    s3_status_r <= s2_status_r;
    s3_temp_r   <= s2_temp_r;
    s4_press_r  <= s3_press_r;
    s4_status_r <= s3_status_r;
    s4_temp_r   <= s3_temp_r;
    s5_press_r  <= s4_press_r;
    s5_status_r <= s4_status_r;
    s5_temp_r   <= s4_temp_r;
  end

  // The ring entry is read while the pressure is scaled and rewritten in the next cycle.
  psfs_ram #(
    .WIDTH(RW),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk    (clk),
    .wr_en  (v2_r),
    .wr_addr(s2_slot_r),
    .wr_data({s2_press_r, s2_temp_r}),
    .rd_addr(slot_r),
    .rd_data(ring_rdata)
  );

  assign slot_nxt = (slot_r == AW'(RING_DEPTH - 1)) ? '0 : slot_r + 1'b1;

  // Entries never written since reset count as zero.
  assign old_press = ring_vld_r[s2_slot_r] ? ring_rdata[RW-1:TEMP_W] : '0;
  assign old_temp  = ring_vld_r[s2_slot_r] ? ring_rdata[TEMP_W-1:0]  : '0;

  assign psum_nxt = psum_r + PUW'(s2_press_r) - PUW'(old_press);
  assign tsum_nxt = tsum_r + TUW'(s2_temp_r) - TUW'(old_temp);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r     <= '0;
      ring_vld_r <= '0;
      psum_r     <= PBIAS;
      tsum_r     <= TBIAS;
    end else begin
      if (v1_r) begin
        slot_r <= slot_nxt;
      end
      if (v2_r) begin
        ring_vld_r[s2_slot_r] <= 1'b1;
        psum_r                <= psum_nxt;
        tsum_r                <= tsum_nxt;
      end
    end
  end

  psfs_avg_div #(
    .VW   (PRESS_W),
    .DEPTH(RING_DEPTH)
  ) u_press_avg (
    .clk       (clk),
    .sum_biased(psum_r),
    .avg       (press_avg)
  );

  psfs_avg_div #(
    .VW   (TEMP_W),
    .DEPTH(RING_DEPTH)
  ) u_temp_avg (
    .clk       (clk),
    .sum_biased(tsum_r),
    .avg       (temp_avg)
  );

  assign res_wr = v5_r;

  always_comb begin
    res.status    = s5_status_r;
    res.press_now = s5_press_r;
    res.temp_now  = s5_temp_r;
    res.press_avg = press_avg;
    res.temp_avg  = temp_avg;
  end

endmodule

>>> sim/psfs_checker.sv
// Scoreboard for the pressure sensor frame scaler: predicts every result and compares it.
module psfs_checker
  import psfs_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  logic                      full,
  input  logic [7:0]                in_byte0,
  input  logic [7:0]                in_byte1,
  input  logic [7:0]                in_byte2,
  input  logic [7:0]                in_byte3,
  input  logic                      empty,
  input  logic                      pop,
  input  logic [STATUS_W-1:0]       out_status_code,
  input  logic signed [PRESS_W-1:0] out_pressure_now,
  input  logic signed [TEMP_W-1:0]  out_temperature_now,
  input  logic signed [PRESS_W-1:0] out_pressure_average,
  input  logic signed [TEMP_W-1:0]  out_temperature_average,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic                      pready,
  input  logic [3:0]                paddr,
  input  logic [31:0]               pwdata,
  input  logic                      run_done,
  output int                        mismatch_count,
  output int                        results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  res_t    awaited_results[$];
  cfg_t    cfg;
  logic [7:0] held_b2;
  logic [7:0] held_b3;
  longint  press_ring[RING_DEPTH];
  longint  temp_ring[RING_DEPTH];
  int      ring_pos;
  longint  press_total;
  longint  temp_total;
  bit      leftovers_checked;

  initial begin
    mismatch_count    = 0;
    results_pending   = 0;
    leftovers_checked = 1'b0;
  end

  task automatic report_failure(input string msg);
    mismatch_count++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  function automatic longint floor_mean(input longint total);
    longint q;
    q = total / RING_DEPTH;
    if (total < 0 && q * RING_DEPTH != total) begin
      q = q - 1;
    end
    return q;
  endfunction

  // Decodes one frame against the current settings and advances the rings.
  function automatic res_t decode_frame(input logic [7:0] b0, input logic [7:0] b1,
                                        input logic [7:0] b2, input logic [7:0] b3);
    logic [13:0] pcount;
    logic [10:0] tcount;
    longint      press;
    longint      temp;
    res_t        r;
    if (cfg.frame_mode == MODE_PARTIAL) begin
      held_b2 = b2;
    end else if (cfg.frame_mode != MODE_PRESS_ONLY) begin
      held_b2 = b2;
      held_b3 = b3;
    end
    // Partial frames carry an 8-bit count; pressure-only and full use the 11-bit form.
    if (cfg.frame_mode == MODE_PARTIAL) begin
      tcount = {3'b000, held_b2};
    end else begin
      tcount = {held_b2, held_b3[7:5]};
    end
    pcount = {b0[5:0], b1};
    press = ((longint'(pcount) - longint'(cfg.offset_counts)) * longint'(cfg.full_scale) * 5)
            >>> 16;
    temp = ((longint'(tcount) * 2501 + 128) >>> 8) - 5000;
    press_total = press_total + press - press_ring[ring_pos];
    temp_total  = temp_total + temp - temp_ring[ring_pos];
    press_ring[ring_pos] = press;
    temp_ring[ring_pos]  = temp;
    ring_pos = (ring_pos + 1) % RING_DEPTH;
    r.status    = b0[7:6];
    r.press_now = PRESS_W'(press);
    r.temp_now  = TEMP_W'(temp);
    r.press_avg = PRESS_W'(floor_mean(press_total));
    r.temp_avg  = TEMP_W'(floor_mean(temp_total));
    return r;
  endfunction

  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      awaited_results.delete();
      cfg.frame_mode    = FRAME_MODE_RST;
      cfg.offset_counts = OFFSET_RST;
      cfg.full_scale    = FULL_SCALE_RST;
      held_b2     = 8'h00;
      held_b3     = 8'h00;
      ring_pos    = 0;
      press_total = 0;
      temp_total  = 0;
      for (int i = 0; i < RING_DEPTH; i++) begin
        press_ring[i] = 0;
        temp_ring[i]  = 0;
      end
    end else begin
      // Results leave only after their frame has passed the pipeline, so check pops before new pushes.
      if (pop && !empty) begin
        if (awaited_results.size() == 0) begin
          report_failure($sformatf("result transfer with nothing expected (pressure %0d)",
                                   out_pressure_now));
        end else begin
          want = awaited_results.pop_front();
          if (out_status_code !== want.status)
            report_failure($sformatf("status_code got %0d expected %0d",
                                     out_status_code, want.status));
          if (out_pressure_now !== want.press_now)
            report_failure($sformatf("pressure_now got %0d expected %0d",
                                     out_pressure_now, want.press_now));
          if (out_temperature_now !== want.temp_now)
            report_failure($sformatf("temperature_now got %0d expected %0d",
                                     out_temperature_now, want.temp_now));
          if (out_pressure_average !== want.press_avg)
            report_failure($sformatf("pressure_average got %0d expected %0d",
                                     out_pressure_average, want.press_avg));
          if (out_temperature_average !== want.temp_avg)
            report_failure($sformatf("temperature_average got %0d expected %0d",
                                     out_temperature_average, want.temp_avg));
        end
      end
      if (push && !full) begin
        awaited_results.push_back(decode_frame(in_byte0, in_byte1, in_byte2, in_byte3));
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_FRAME_MODE: cfg.frame_mode    = pwdata[MODE_W-1:0];
          REG_OFFSET:     cfg.offset_counts = pwdata[OFS_W-1:0];
          REG_FULL_SCALE: cfg.full_scale    = pwdata[FS_W-1:0];
          default: ;
        endcase
      end
      if (run_done && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (awaited_results.size() != 0) begin
          report_failure($sformatf("%0d expected results never arrived",
                                   awaited_results.size()));
        end
      end
    end
    results_pending = awaited_results.size();
  end

endmodule

>>> sim/tb_top.sv
// Testbench top for the pressure sensor frame scaler: clock, reset, stimulus and verdict.
module tb_top;
  import psfs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]        REG_SPARE   = 2'd3;
  localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;
  localparam int                PHASE_ITEMS = 340;
  localparam int                NUM_PHASES  = 6;

  logic                      clk;
  logic                      rst_n;
  logic                      push;
  logic                      full;
  logic [7:0]                in_byte0;
  logic [7:0]                in_byte1;
  logic [7:0]                in_byte2;
  logic [7:0]                in_byte3;
  logic                      empty;
  logic                      pop;
  logic [STATUS_W-1:0]       out_status_code;
  logic signed [PRESS_W-1:0] out_pressure_now;
  logic signed [TEMP_W-1:0]  out_temperature_now;
  logic signed [PRESS_W-1:0] out_pressure_average;
  logic signed [TEMP_W-1:0]  out_temperature_average;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [3:0]                paddr;
  logic [31:0]               pwdata;
  logic [31:0]               prdata;
  logic                      pready;
  logic                      run_done;
  int                        mismatch_count;
  int                        results_pending;

  int                        send_idle_pct;
  int                        stall_pct;
  bit                        hold_off;
  logic [OFS_W-1:0]          cur_offset;

  pressure_sensor_frame_scaler_unit i_dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .push                    (push),
    .full                    (full),
    .in_byte0                (in_byte0),
    .in_byte1                (in_byte1),
    .in_byte2                (in_byte2),
    .in_byte3                (in_byte3),
    .empty                   (empty),
    .pop                     (pop),
    .out_status_code         (out_status_code),
    .out_pressure_now        (out_pressure_now),
    .out_temperature_now     (out_temperature_now),
    .out_pressure_average    (out_pressure_average),
    .out_temperature_average (out_temperature_average),
    .psel                    (psel),
    .penable                 (penable),
    .pwrite                  (pwrite),
    .paddr                   (paddr),
    .pwdata                  (pwdata),
    .prdata                  (prdata),
    .pready                  (pready)
  );

  psfs_checker i_check (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .push                    (push),
    .full                    (full),
    .in_byte0                (in_byte0),
    .in_byte1                (in_byte1),
    .in_byte2                (in_byte2),
    .in_byte3                (in_byte3),
    .empty                   (empty),
    .pop                     (pop),
    .out_status_code         (out_status_code),
    .out_pressure_now        (out_pressure_now),
    .out_temperature_now     (out_temperature_now),
    .out_pressure_average    (out_pressure_average),
    .out_temperature_average (out_temperature_average),
    .psel                    (psel),
    .penable                 (penable),
    .pwrite                  (pwrite),
    .pready                  (pready),
    .paddr                   (paddr),
    .pwdata                  (pwdata),
    .run_done                (run_done),
    .mismatch_count          (mismatch_count),
    .results_pending         (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side: pops at random, or not at all while a hold-off is in force.
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      pop <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_OFFSET) begin
      cur_offset = data[OFS_W-1:0];
    end
  endtask

  task automatic send_frame(input logic [7:0] b0, input logic [7:0] b1,
                            input logic [7:0] b2, input logic [7:0] b3);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push     <= 1'b1;
    in_byte0 <= b0;
    in_byte1 <= b1;
    in_byte2 <= b2;
    in_byte3 <= b3;
    do @(posedge clk); while (full);
  endtask

  task automatic send_random_frame();
    logic [13:0] pc;
    logic [7:0]  hi;
    case ($urandom_range(0, 9))
      0: pc = cur_offset + 14'($urandom_range(0, 8)) - 14'd4;
      1: pc = 14'h0000;
      2: pc = 14'h3fff;
      default: pc = 14'($urandom);
    endcase
    hi = {2'($urandom), pc[13:8]};
    send_frame(hi, pc[7:0], 8'($urandom), 8'($urandom));
  endtask

  // Stop offering frames, then wait until every transferred frame has come back out
  // before the settings change. The count is read away from the rising edge.
  task automatic wait_idle();
    @(negedge clk);
    push <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (3) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [MODE_W-1:0] ph_mode;
    logic [OFS_W-1:0]  ph_offset;
    logic [FS_W-1:0]   ph_scale;
    rst_n         = 1'b0;
    push          = 1'b0;
    in_byte0      = 8'h00;
    in_byte1      = 8'h00;
    in_byte2      = 8'h00;
    in_byte3      = 8'h00;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = 4'h0;
    pwdata        = 32'h0;
    run_done      = 1'b0;
    hold_off      = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    cur_offset    = OFFSET_RST;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Settings out of reset: full frames, offset 1638, full scale 10000.
    send_frame(8'h00, 8'h00, 8'h00, 8'h00);
    send_frame(8'hff, 8'hff, 8'hff, 8'hff);
    send_frame(8'h46, 8'h66, 8'h80, 8'h1f);  // count equals the offset
    send_frame(8'h86, 8'h65, 8'h7f, 8'he0);  // one count below the offset
    send_frame(8'hc6, 8'h67, 8'h55, 8'ha0);

    wait_idle();
    cfg_write(REG_FRAME_MODE, 32'(MODE_PARTIAL));
    send_frame(8'h12, 8'h34, 8'hff, 8'h00);
    send_frame(8'h56, 8'h78, 8'h00, 8'hff);
    send_frame(8'h9a, 8'hbc, 8'hab, 8'h5a);

    // Pressure-only frames reuse the temperature bytes held from earlier frames.
    wait_idle();
    cfg_write(REG_FRAME_MODE, 32'(MODE_PRESS_ONLY));
    send_frame(8'h21, 8'h43, 8'h11, 8'h22);
    send_frame(8'he5, 8'h87, 8'hff, 8'hff);
    send_frame(8'h3f, 8'hfe, 8'h00, 8'h00);

    // The undefined mode decodes as a full frame.
    wait_idle();
    cfg_write(REG_FRAME_MODE, 32'(MODE_SPARE));
    send_frame(8'h7f, 8'h00, 8'hc3, 8'he0);
    send_frame(8'h80, 8'hff, 8'h3c, 8'h20);

    // A write past the last register must change nothing; zero full scale flattens pressure.
    wait_idle();
    cfg_write(REG_SPARE, 32'hffff_ffff);
    cfg_write(REG_FULL_SCALE, 32'h0);
    send_frame(8'hff, 8'hff, 8'h01, 8'h80);
    send_frame(8'h00, 8'h01, 8'hfe, 8'h40);

    wait_idle();
    cfg_write(REG_OFFSET, 32'(14'h3fff));
    cfg_write(REG_FULL_SCALE, 32'(16'hffff));
    send_frame(8'h00, 8'h00, 8'hff, 8'he0);
    send_frame(8'h3f, 8'hff, 8'h00, 8'h00);
    send_frame(8'hc0, 8'h01, 8'h80, 8'h60);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: begin ph_mode = MODE_FULL;       ph_offset = 14'd0;     ph_scale = 16'hffff; end
        1: begin ph_mode = MODE_PARTIAL;    ph_offset = 14'h3fff;  ph_scale = 16'hffff; end
        2: begin ph_mode = MODE_PRESS_ONLY; ph_offset = 14'd8000;  ph_scale = 16'd1;    end
        3: begin ph_mode = MODE_SPARE;      ph_offset = 14'($urandom); ph_scale = 16'd0; end
        4: begin ph_mode = MODE_FULL;       ph_offset = OFFSET_RST; ph_scale = FULL_SCALE_RST; end
        default: begin
          ph_mode   = MODE_PARTIAL;
          ph_offset = 14'($urandom);
          ph_scale  = 16'($urandom);
        end
      endcase
      // Unused upper data bits carry noise; the registers keep only their own width.
      cfg_write(REG_FRAME_MODE, {30'($urandom), ph_mode});
      cfg_write(REG_OFFSET, {18'($urandom), ph_offset});
      cfg_write(REG_FULL_SCALE, {16'($urandom), ph_scale});
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 55; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 55; end
        default: begin send_idle_pct = 22; stall_pct = 22; end
      endcase
      if (ph == 4) begin
        // Hold the result side off long enough for the queues to fill and stall the input.
        fork
          for (int k = 0; k < PHASE_ITEMS; k++) send_random_frame();
          begin
            repeat (30) @(posedge clk);
            hold_off = 1'b1;
            repeat (80) @(posedge clk);
            hold_off = 1'b0;
          end
        join
      end else begin
        for (int k = 0; k < PHASE_ITEMS; k++) send_random_frame();
      end
    end

    @(negedge clk);
    push <= 1'b0;
    for (int k = 0; k < 5000 && results_pending != 0; k++) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
    run_done <= 1'b1;
    @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
